@@ sv/hpsr_pkg.sv @@
// ----------------------------------------------------------------------------
// hpsr_pkg
// Shared widths, register indexes and the configuration bundle for the
// heading PID controller with integral reset.
// ----------------------------------------------------------------------------
package hpsr_pkg;

    localparam int unsigned GAIN_SHIFT_DEF = 12;

    localparam int unsigned ANGLE_W   = 16;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned GAIN_W    = 24;
    localparam int unsigned LIMIT_W   = 15;
    localparam int unsigned STEP_W    = 16;
    localparam int unsigned ACC_W     = 32;
    localparam int unsigned DRIVE_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // Serial multiplier: gain side goes in one digit per cycle.
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned NDIGITS  = GAIN_W / DIGIT_W;
    localparam int unsigned DCNT_W   = $clog2(NDIGITS + 1);
    localparam int unsigned PAR_W    = ACC_W + 1;
    localparam int unsigned HI_W     = PAR_W + DIGIT_W + 1;
    localparam int unsigned PROD_W   = PAR_W + GAIN_W;
    localparam int unsigned SUM_W    = PROD_W + 1;

    localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 15'd32767;
    localparam logic [STEP_W-1:0]  STEP_TIME_RST   = 16'd655;
    localparam int                 DRIVE_MAX       = 32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_DERIV_GAIN  = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_INTEG_LIMIT = 3'd3,
        REG_STEP_TIME   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic [LIMIT_W-1:0]       integ_limit;
        logic [STEP_W-1:0]        step_time;
    } cfg_bundle_t;

endpackage

@@ sv/hpsr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// hpsr_cfg_regs
// Configuration register file: decodes write beats by index and holds the
// gains, integral limit and control period.
// ----------------------------------------------------------------------------
module hpsr_cfg_regs import hpsr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [GAIN_W-1:0]    cfg_data,
    output cfg_bundle_t          cfg
);

    cfg_bundle_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain   <= '0;
            cfg_reg.deriv_gain  <= '0;
            cfg_reg.integ_gain  <= '0;
            cfg_reg.integ_limit <= INTEG_LIMIT_RST;
            cfg_reg.step_time   <= STEP_TIME_RST;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_PROP_GAIN:   cfg_reg.prop_gain   <= cfg_data;
                REG_DERIV_GAIN:  cfg_reg.deriv_gain  <= cfg_data;
                REG_INTEG_GAIN:  cfg_reg.integ_gain  <= cfg_data;
                REG_INTEG_LIMIT: cfg_reg.integ_limit <= cfg_data[LIMIT_W-1:0];
                REG_STEP_TIME:   cfg_reg.step_time   <= cfg_data[STEP_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

endmodule

@@ sv/hpsr_serial_mul.sv @@
// ----------------------------------------------------------------------------
// hpsr_serial_mul
// Digit-serial signed multiplier. The gain operand is shifted in one 4-bit
// digit per cycle, least significant first; the top digit carries the sign.
// ----------------------------------------------------------------------------
module hpsr_serial_mul import hpsr_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [GAIN_W-1:0] gain,
    input  logic signed [PAR_W-1:0]  par,
    output logic                     done,
    output logic signed [PROD_W-1:0] prod
);

    logic [GAIN_W-1:0]       b_reg;
    logic signed [PAR_W-1:0] a_reg;
    logic signed [HI_W-1:0]  hi_reg;
    logic [GAIN_W-1:0]       lo_reg;
    logic [DCNT_W-1:0]       cnt_reg;
    logic                    done_reg;

    logic                    last_digit;
    logic signed [DIGIT_W:0] digit;
    logic signed [HI_W-1:0]  pp;
    logic signed [HI_W-1:0]  psum;

    always_comb begin
        last_digit = (cnt_reg == DCNT_W'(1));
        digit = last_digit ? {b_reg[DIGIT_W-1], b_reg[DIGIT_W-1:0]}
                           : {1'b0, b_reg[DIGIT_W-1:0]};
        pp   = a_reg * digit;
        psum = hi_reg + pp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                a_reg    <= par;
                b_reg    <= gain;
                hi_reg   <= '0;
                lo_reg   <= '0;
                cnt_reg  <= DCNT_W'(NDIGITS);
                done_reg <= 1'b0;
            end else if (cnt_reg != '0) begin
                // shift the finished low digit out into the low word
                hi_reg   <= psum >>> DIGIT_W;
                lo_reg   <= {psum[DIGIT_W-1:0], lo_reg[GAIN_W-1:DIGIT_W]};
                b_reg    <= b_reg >> DIGIT_W;
                cnt_reg  <= cnt_reg - DCNT_W'(1);
                done_reg <= last_digit;
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg[PAR_W-1:0], lo_reg};

endmodule

@@ sv/heading_pid_sign_reset_top.sv @@
// ----------------------------------------------------------------------------
// heading_pid_sign_reset_top
// Heading PID controller: wrapped heading error, saturating error*dt
// integral cleared on target change or error sign change, P + D + clamped I.
//
// Usage:
//   s_* channel carries one beat per control tick (current heading, heading
//   rate, target heading, target x, target y). m_* channel returns one
//   angular_drive beat (Q1.15, within +/-32767) per input beat.
//   cfg_* channel writes gains, integral limit and period by index; it is
//   always ready; the user must write it only while no tick is in flight,
//   which the block itself does not enforce.
// Datapath:
//   Four products (error*dt, Kp, Kd, Ki) go one after the other through a
//   single digit-serial multiplier that takes the gain one digit at a time.
//   A new beat is taken only once the result is in the output register.
// Reset: aresetn (synchronous, active low) clears the integral, the stored
//   error and target, and loads the register reset values.
// Stall: a pending result sits in the output register while the next beat is
//   accepted; the finished sum is loaded once that register is empty or taken.
// ----------------------------------------------------------------------------
module heading_pid_sign_reset_top import hpsr_pkg::*; #(
    parameter int unsigned GAIN_SHIFT = GAIN_SHIFT_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_addr,
    input  logic [GAIN_W-1:0]         cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [ANGLE_W-1:0] s_current_heading,
    input  logic signed [ANGLE_W-1:0] s_heading_rate,
    input  logic signed [ANGLE_W-1:0] s_target_heading,
    input  logic signed [POS_W-1:0]   s_target_x,
    input  logic signed [POS_W-1:0]   s_target_y,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DRIVE_W-1:0] m_angular_drive
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_PROP,
        ST_DERIV,
        ST_INTEG,
        ST_OUT
    } state_t;

    cfg_bundle_t cfg;

    state_t                      state_reg;
    logic                        start_reg;
    logic signed [ACC_W-1:0]     integ_acc_reg;
    logic signed [ANGLE_W-1:0]   last_err_reg;
    logic [ANGLE_W-1:0]          last_th_reg;
    logic [POS_W-1:0]            last_tx_reg;
    logic [POS_W-1:0]            last_ty_reg;
    logic                        seen_reg;
    logic signed [ANGLE_W-1:0]   err_reg;
    logic signed [ANGLE_W:0]     rate_neg_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic                        m_valid_reg;
    logic signed [DRIVE_W-1:0]   m_drive_reg;

    logic                        s_accept;
    logic                        tgt_change;
    logic signed [ANGLE_W-1:0]   err_in;
    logic signed [ANGLE_W:0]     rate_neg_in;

    logic signed [GAIN_W-1:0]    mul_gain;
    logic signed [PAR_W-1:0]     mul_par;
    logic                        mul_done;
    logic signed [PROD_W-1:0]    mul_prod;

    logic signed [ACC_W+1:0]     acc_sum;
    logic signed [ACC_W-1:0]     acc_sat;
    logic                        sign_flip;
    logic signed [PROD_W-1:0]    gain_term;
    logic signed [PROD_W-1:0]    integ_shift;
    logic signed [PROD_W-1:0]    lim_pos;
    logic signed [DRIVE_W-1:0]   integ_term;
    logic signed [SUM_W-1:0]     drive_hi;
    logic signed [DRIVE_W-1:0]   drive_sat;
    logic                        out_free;
    logic                        start_next;
    logic                        m_valid_next;

    hpsr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hpsr_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .gain    (mul_gain),
        .par     (mul_par),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        tgt_change  = !seen_reg || (s_target_heading != last_th_reg) ||
                      (s_target_x != last_tx_reg) || (s_target_y != last_ty_reg);
        err_in      = s_target_heading - s_current_heading;
        rate_neg_in = -{s_heading_rate[ANGLE_W-1], s_heading_rate};

        case (state_reg)
            ST_ACC: begin
                mul_gain = {{(GAIN_W-STEP_W){1'b0}}, cfg.step_time};
                mul_par  = PAR_W'(err_reg);
            end
            ST_PROP: begin
                mul_gain = cfg.prop_gain;
                mul_par  = PAR_W'(err_reg);
            end
            ST_DERIV: begin
                mul_gain = cfg.deriv_gain;
                mul_par  = PAR_W'(rate_neg_reg);
            end
            ST_INTEG: begin
                mul_gain = cfg.integ_gain;
                mul_par  = PAR_W'(integ_acc_reg);
            end
            default: begin
                mul_gain = '0;
                mul_par  = '0;
            end
        endcase

        // integral update: saturate to 32 bits
        acc_sum = (ACC_W+2)'(integ_acc_reg) + (ACC_W+2)'($signed(mul_prod[PAR_W-1:0]));
        if (acc_sum[ACC_W+1:ACC_W-1] == 3'b000 || acc_sum[ACC_W+1:ACC_W-1] == 3'b111) begin
            acc_sat = acc_sum[ACC_W-1:0];
        end else if (acc_sum[ACC_W+1]) begin
            acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
        end
        sign_flip = (last_err_reg != '0) && (err_reg != '0) &&
                    (last_err_reg[ANGLE_W-1] != err_reg[ANGLE_W-1]);

        // arithmetic shift rounds toward minus infinity
        gain_term   = mul_prod >>> GAIN_SHIFT;
        integ_shift = mul_prod >>> (GAIN_SHIFT + 16);
        lim_pos     = PROD_W'(cfg.integ_limit);
        if (integ_shift > lim_pos) begin
            integ_term = DRIVE_W'(cfg.integ_limit);
        end else if (integ_shift < -lim_pos) begin
            integ_term = -DRIVE_W'(cfg.integ_limit);
        end else begin
            integ_term = integ_shift[DRIVE_W-1:0];
        end

        drive_hi = SUM_W'(DRIVE_MAX);
        if (sum_reg > drive_hi) begin
            drive_sat = DRIVE_W'(DRIVE_MAX);
        end else if (sum_reg < -drive_hi) begin
            drive_sat = -DRIVE_W'(DRIVE_MAX);
        end else begin
            drive_sat = sum_reg[DRIVE_W-1:0];
        end

        // kick the multiplier on an accepted beat and after each product but the last
        start_next = s_accept ||
                     (mul_done && (state_reg == ST_ACC || state_reg == ST_PROP ||
                                   state_reg == ST_DERIV));

        if (state_reg == ST_OUT && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            integ_acc_reg <= '0;
            last_err_reg  <= '0;
            last_th_reg   <= '0;
            last_tx_reg   <= '0;
            last_ty_reg   <= '0;
            seen_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (tgt_change) begin
                            integ_acc_reg <= '0;
                            last_th_reg   <= s_target_heading;
                            last_tx_reg   <= s_target_x;
                            last_ty_reg   <= s_target_y;
                            seen_reg      <= 1'b1;
                        end
                        err_reg      <= err_in;
                        rate_neg_reg <= rate_neg_in;
                        state_reg    <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (mul_done) begin
                        integ_acc_reg <= sign_flip ? '0 : acc_sat;
                        last_err_reg  <= err_reg;
                        state_reg     <= ST_PROP;
                    end
                end
                ST_PROP: begin
                    if (mul_done) begin
                        sum_reg   <= SUM_W'(gain_term);
                        state_reg <= ST_DERIV;
                    end
                end
                ST_DERIV: begin
                    if (mul_done) begin
                        sum_reg   <= sum_reg + SUM_W'(gain_term);
                        state_reg <= ST_INTEG;
                    end
                end
                ST_INTEG: begin
                    if (mul_done) begin
                        sum_reg   <= sum_reg + SUM_W'(integ_term);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold the sum until the output register frees up
                    if (out_free) begin
                        m_drive_reg <= drive_sat;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_angular_drive = m_drive_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("input taken while previous tick still in flight");

    a_done_in_mul_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_ACC || state_reg == ST_PROP ||
                      state_reg == ST_DERIV || state_reg == ST_INTEG))
        else $error("multiplier finished outside a product step");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised without a finished sum");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_drive_reg != {1'b1, {(DRIVE_W-1){1'b0}}}))
        else $error("drive outside the saturated range");

    a_target_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> seen_reg)
        else $error("target not recorded after an input beat");

endmodule

@@ tb/hpsr_drive_checker.sv @@
// ----------------------------------------------------------------------------
// hpsr_drive_checker
// Watches the configuration, tick and drive channels of the heading PID
// block. It keeps its own copy of the registers, integral, previous error and
// target pose, and predicts one angular_drive value per accepted tick. Each
// drive beat is compared with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hpsr_drive_checker import hpsr_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_addr,
    input  logic [GAIN_W-1:0]         cfg_data,

    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic signed [ANGLE_W-1:0] s_current_heading,
    input  logic signed [ANGLE_W-1:0] s_heading_rate,
    input  logic signed [ANGLE_W-1:0] s_target_heading,
    input  logic signed [POS_W-1:0]   s_target_x,
    input  logic signed [POS_W-1:0]   s_target_y,

    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [DRIVE_W-1:0] m_angular_drive,

    output int                        fail_count,
    output int                        pending,
    output int                        checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned GAIN_SHIFT = GAIN_SHIFT_DEF;
    localparam longint ACC_TOP = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_BOT = -(longint'(1) <<< (ACC_W - 1));

    // register copy
    logic signed [GAIN_W-1:0] kp, kd, ki;
    logic [LIMIT_W-1:0]       i_lim;
    logic [STEP_W-1:0]        dt;

    // controller state
    logic signed [ACC_W-1:0]   integ_sum;
    logic signed [ANGLE_W-1:0] prev_err;
    logic signed [ANGLE_W-1:0] tgt_heading;
    logic signed [POS_W-1:0]   tgt_x, tgt_y;
    logic                      tgt_valid;

    logic signed [DRIVE_W-1:0] drive_q [$];

    function automatic logic signed [DRIVE_W-1:0] next_drive(
        input logic signed [ANGLE_W-1:0] cur,
        input logic signed [ANGLE_W-1:0] rate,
        input logic signed [ANGLE_W-1:0] th,
        input logic signed [POS_W-1:0]   tx,
        input logic signed [POS_W-1:0]   ty
    );
        logic signed [ANGLE_W-1:0] err;
        longint acc, pterm, dterm, iterm, total;
        // a new target pose restarts the integral
        if (!tgt_valid || th != tgt_heading || tx != tgt_x || ty != tgt_y) begin
            integ_sum   = '0;
            tgt_heading = th;
            tgt_x       = tx;
            tgt_y       = ty;
            tgt_valid   = 1'b1;
        end
        err = th - cur;  // wraps to a half turn
        acc = longint'(integ_sum) + longint'(err) * longint'(dt);
        if (acc > ACC_TOP) acc = ACC_TOP;
        if (acc < ACC_BOT) acc = ACC_BOT;
        integ_sum = ACC_W'(acc);
        // opposite nonzero signs drop what was just accumulated
        if ((prev_err > 0 && err < 0) || (prev_err < 0 && err > 0)) integ_sum = '0;
        prev_err = err;

        pterm = (longint'(kp) * longint'(err)) >>> GAIN_SHIFT;
        dterm = (longint'(kd) * -longint'(rate)) >>> GAIN_SHIFT;
        iterm = (longint'(ki) * longint'(integ_sum)) >>> (GAIN_SHIFT + 16);
        if (iterm > longint'(i_lim)) iterm = longint'(i_lim);
        if (iterm < -longint'(i_lim)) iterm = -longint'(i_lim);
        total = pterm + dterm + iterm;
        if (total > longint'(DRIVE_MAX)) total = longint'(DRIVE_MAX);
        if (total < -longint'(DRIVE_MAX)) total = -longint'(DRIVE_MAX);
        return DRIVE_W'(total);
    endfunction

    task automatic report_miss(input string what);
        fail_count++;
        $display("[%0t] drive check: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin : watch
        logic signed [DRIVE_W-1:0] want;
        if (!aresetn) begin
            kp          = '0;
            kd          = '0;
            ki          = '0;
            i_lim       = INTEG_LIMIT_RST;
            dt          = STEP_TIME_RST;
            integ_sum   = '0;
            prev_err    = '0;
            tgt_heading = '0;
            tgt_x       = '0;
            tgt_y       = '0;
            tgt_valid   = 1'b0;
            drive_q.delete();
            fail_count  = 0;
            checked     = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_PROP_GAIN:   kp = cfg_data;
                    REG_DERIV_GAIN:  kd = cfg_data;
                    REG_INTEG_GAIN:  ki = cfg_data;
                    REG_INTEG_LIMIT: i_lim = cfg_data[LIMIT_W-1:0];
                    REG_STEP_TIME:   dt = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    report_miss($sformatf("angular_drive %0d with no tick outstanding",
                                          m_angular_drive));
                end else begin
                    want = drive_q.pop_front();
                    checked++;
                    if (m_angular_drive !== want)
                        report_miss($sformatf("beat %0d: angular_drive %0d, predicted %0d",
                                              checked, m_angular_drive, want));
                end
            end
            if (s_valid && s_ready)
                drive_q.push_back(next_drive(s_current_heading, s_heading_rate,
                                             s_target_heading, s_target_x, s_target_y));
        end
        pending <= drive_q.size();
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the heading PID block through a series of register settings: reset
// values, a directed set of ticks around wrap, half turn, first target and
// integral clears, then steady, dithering and wandering error runs against
// held targets mixed with noise and broken target sequences. The sender
// idles in bursts, the receiver stalls on its own pattern, and a checker
// beside the block predicts and compares every drive beat.
// ----------------------------------------------------------------------------
module testbench import hpsr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_addr = '0;
    logic [GAIN_W-1:0]         cfg_data = '0;

    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [ANGLE_W-1:0] s_current_heading = '0;
    logic signed [ANGLE_W-1:0] s_heading_rate = '0;
    logic signed [ANGLE_W-1:0] s_target_heading = '0;
    logic signed [POS_W-1:0]   s_target_x = '0;
    logic signed [POS_W-1:0]   s_target_y = '0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [DRIVE_W-1:0] m_angular_drive;

    int fail_count;
    int pending;
    int checked;

    int burst_left = 0;
    int n_ticks = 0;
    int n_settings = 0;

    heading_pid_sign_reset_top i_dut (.*);

    hpsr_drive_checker i_chk (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver: always ready, coin flips, or long stall/run stretches
    int ready_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    logic hold_level = 1'b1;

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(100, 400);
        end
        mode_left--;
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (hold_left == 0) begin
                    hold_level = !hold_level;
                    hold_left  = $urandom_range(1, 24);
                end
                hold_left--;
                m_ready <= hold_level;
            end
        endcase
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return ANGLE_W'(16'h8000);
            1: return ANGLE_W'(16'h7fff);
            2: return ANGLE_W'(0);
            3: return ANGLE_W'(16'hffff);
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 7))
            0: return POS_W'(32'h8000_0000);
            1: return POS_W'(32'h7fff_ffff);
            2: return POS_W'(0);
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [GAIN_W-1:0] rand_gain();
        return $signed(GAIN_W'($urandom)) >>> $urandom_range(0, GAIN_W - 1);
    endfunction

    task automatic send_tick(
        input logic signed [ANGLE_W-1:0] cur,
        input logic signed [ANGLE_W-1:0] rate,
        input logic signed [ANGLE_W-1:0] th,
        input logic signed [POS_W-1:0]   tx,
        input logic signed [POS_W-1:0]   ty
    );
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid           <= 1'b1;
        s_current_heading <= cur;
        s_heading_rate    <= rate;
        s_target_heading  <= th;
        s_target_x        <= tx;
        s_target_y        <= ty;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_ticks++;
    endtask

    // hold the sender until every predicted drive beat has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [GAIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic load_setting(input cfg_bundle_t c);
        write_reg(REG_PROP_GAIN, c.prop_gain);
        write_reg(REG_DERIV_GAIN, c.deriv_gain);
        write_reg(REG_INTEG_GAIN, c.integ_gain);
        write_reg(REG_INTEG_LIMIT, GAIN_W'(c.integ_limit));
        write_reg(REG_STEP_TIME, GAIN_W'(c.step_time));
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_phase(input int n);
        logic signed [ANGLE_W-1:0] th, off, rate;
        logic signed [POS_W-1:0]   tx, ty;
        int len, style;
        while (n > 0) begin
            th    = rand_angle();
            tx    = rand_pos();
            ty    = rand_pos();
            style = $urandom_range(0, 9);
            if (style == 0) len = 1;
            else if ($urandom_range(0, 7) == 0) len = $urandom_range(60, 160);
            else len = $urandom_range(2, 30);
            off = $signed(rand_angle()) >>> $urandom_range(0, 15);
            for (int k = 0; k < len && n > 0; k++) begin
                case (style)
                    0: off = rand_angle();
                    1, 2, 3: ;  // hold the error, let the integral run
                    4, 5, 6: off = ANGLE_W'(int'($urandom_range(0, 32)) - 16);
                    default: begin
                        off = off + ANGLE_W'(int'($urandom_range(0, 64)) - 32);
                        if ($urandom_range(0, 7) == 0) off = off >>> 1;
                    end
                endcase
                rate = ($urandom_range(0, 1) == 0) ? rand_angle()
                                                   : ANGLE_W'(int'($urandom_range(0, 512)) - 256);
                // break the sequence now and then by nudging the target pose
                if ($urandom_range(0, 40) == 0) begin
                    case ($urandom_range(0, 2))
                        0: th = th ^ (ANGLE_W'(1) << $urandom_range(0, ANGLE_W - 1));
                        1: tx = tx ^ (POS_W'(1) << $urandom_range(0, POS_W - 1));
                        default: ty = ty ^ (POS_W'(1) << $urandom_range(0, POS_W - 1));
                    endcase
                end
                send_tick(th - off, rate, th, tx, ty);
                n--;
            end
            if ($urandom_range(0, 19) == 0) drain();
        end
    endtask

    initial begin : stimulus
        cfg_bundle_t c;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // register reset values: zero gains
        run_phase(6);
        drain();

        c = '{prop_gain: 24'sd4096, deriv_gain: 24'sd1024, integ_gain: 24'sd65536,
              integ_limit: 15'd20000, step_time: 16'd655};
        load_setting(c);
        // first target equals the cleared stored pose
        send_tick(-16'sd100, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        send_tick(-16'sd50, 16'sd7, 16'sd0, 32'sd0, 32'sd0);
        // zero error between errors of opposite sign does not clear
        send_tick(16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        send_tick(16'sd100, -16'sd7, 16'sd0, 32'sd0, 32'sd0);
        // direct sign flip clears
        send_tick(-16'sd100, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        // wrap across the half turn boundary both ways
        send_tick(16'sh7fff, 16'sd0, -16'sh8000, 32'sd0, 32'sd0);
        send_tick(-16'sh8000, 16'sd0, 16'sh7fff, 32'sd0, 32'sd0);
        // exactly a half turn off, rate extremes
        send_tick(16'sd0, -16'sh8000, -16'sh8000, 32'sd0, 32'sd0);
        send_tick(16'sd0, 16'sh7fff, -16'sh8000, 32'sd0, 32'sd0);
        // only x, then only y, then x again of the pose changes; the last tick repeats it
        send_tick(16'sd0, 16'sd0, -16'sh8000, 32'sd1, 32'sd0);
        send_tick(16'sd0, 16'sd0, -16'sh8000, 32'sd1, -32'sh8000_0000);
        send_tick(16'sd0, 16'sd0, -16'sh8000, 32'sh7fff_ffff, -32'sh8000_0000);
        send_tick(16'sd0, 16'sd0, -16'sh8000, 32'sh7fff_ffff, -32'sh8000_0000);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: c = '{prop_gain: 24'sh7fffff, deriv_gain: 24'sh800000,
                         integ_gain: 24'sh7fffff, integ_limit: 15'd0, step_time: 16'hffff};
                1: c = '{prop_gain: 24'sh800000, deriv_gain: 24'sh7fffff,
                         integ_gain: 24'sh800000, integ_limit: 15'h7fff, step_time: 16'h0};
                2: c = '{prop_gain: 24'sd4096, deriv_gain: 24'sd0,
                         integ_gain: 24'sh7fffff, integ_limit: 15'h7fff, step_time: 16'hffff};
                default: begin
                    c.prop_gain   = rand_gain();
                    c.deriv_gain  = rand_gain();
                    c.integ_gain  = rand_gain();
                    c.integ_limit = ($urandom_range(0, 3) == 0) ? INTEG_LIMIT_RST
                                                                : LIMIT_W'($urandom);
                    c.step_time   = STEP_W'($urandom >> $urandom_range(0, 15));
                end
            endcase
            drain();
            load_setting(c);
            run_phase(170);
        end

        drain();
        repeat (40) @(posedge aclk);
        $display("Drove %0d ticks, compared %0d drive beats over %0d register settings",
                 n_ticks, checked, n_settings);
        $display("Settings spanned zero and full-scale gains, zero limit, zero and max period");
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
